>>> rtl/ibsc_pkg.sv
// shared types, constants and tables of the induction balance signal classifier
`timescale 1ns / 1ps
package ibsc_pkg;

   localparam int unsigned CAL_SAMPLES = 100;
   localparam int unsigned CORDIC_STEPS = 15;
   localparam int unsigned DIV_BITS = 24;

   localparam logic [1:0] REG_DETECT_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_BALANCE_ENABLE = 2'd1;
   localparam logic [1:0] REG_BALANCE_INTERVAL = 2'd2;

   localparam logic signed [16:0] PI_UNITS = 17'sd46083;
   localparam logic [9:0] THRESHOLD_RESET = 10'd50;
   localparam logic [15:0] INTERVAL_RESET = 16'd500;

   typedef struct packed {
      logic start;
      logic signed [DIV_BITS:0] num;
      logic [15:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic signed [DIV_BITS:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic start;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } cordic_req_type;

   typedef struct packed {
      logic done;
      logic signed [8:0] phase;
   } cordic_rsp_type;

   function automatic logic [13:0] atan_unit(input logic [3:0] i);
      logic [13:0] v;
      unique case (i)
         4'd0: v = 14'd11521;
         4'd1: v = 14'd6801;
         4'd2: v = 14'd3594;
         4'd3: v = 14'd1824;
         4'd4: v = 14'd916;
         4'd5: v = 14'd458;
         4'd6: v = 14'd229;
         4'd7: v = 14'd115;
         4'd8: v = 14'd57;
         4'd9: v = 14'd29;
         4'd10: v = 14'd14;
         4'd11: v = 14'd7;
         4'd12: v = 14'd4;
         4'd13: v = 14'd2;
         4'd14: v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/induction_balance_signal_classifier.sv
// top level: sequencer, state, registers and result register of the classifier
//
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    req_sample, req_now_ms
// rsp      out        rsp_valid/rsp_ready    rsp_calibrating .. rsp_tone_freq
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// a calibration sample adds to the sum, the last one also runs the /100 divide
// a detection runs the balance divide when due, the cordic and the two divides,
// on the shared 24-step divider and the 15-step cordic loop
// synchronous reset clears the state and the registers to their defaults
// a new transaction is taken while the previous result waits for rsp_ready
`timescale 1ns / 1ps
module induction_balance_signal_classifier (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_sample,
   input  logic [31:0] req_now_ms,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_calibrating,
   output logic signed [15:0] rsp_difference,
   output logic signed [7:0] rsp_target_index,
   output logic rsp_tone_on,
   output logic [15:0] rsp_tone_freq,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);
   import ibsc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_DIV_CAL = 7'b0000010,
      ST_DIV_BAL = 7'b0000100,
      ST_CORDIC  = 7'b0001000,
      ST_DIV_A10 = 7'b0010000,
      ST_DIV_VDI = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic launch_ff, launch_in;
   logic [9:0] thr_ff;
   logic bal_en_ff;
   logic [15:0] interval_ff;
   logic signed [15:0] base_ff, base_in;
   logic signed [23:0] sum_ff, sum_in;
   logic [8:0] count_ff, count_in;
   logic [31:0] last_ff, last_in;
   logic signed [15:0] s_ff, s_in;
   logic [31:0] now_ff, now_in;
   logic signed [15:0] d_ff, d_in;
   logic [16:0] a_ff, a_in;
   logic cal_ff, cal_in;
   logic tone_ff, tone_in;
   logic [11:0] a10p1_ff, a10p1_in;
   logic signed [7:0] vdi_ff, vdi_in;
   logic out_valid_ff, out_valid_in;
   logic out_cal_ff, out_cal_in;
   logic signed [15:0] out_diff_ff, out_diff_in;
   logic signed [7:0] out_vdi_ff, out_vdi_in;
   logic out_tone_ff, out_tone_in;
   logic [15:0] out_freq_ff, out_freq_in;

   div_req_type div_req;
   div_rsp_type div_rsp;
   cordic_req_type cordic_req;
   cordic_rsp_type cordic_rsp;

   logic signed [15:0] d_new;
   logic [16:0] a_new;
   logic bal_go;
   logic detect;
   logic signed [24:0] vdi_prod;
   logic [17:0] freq_sum;
   logic [15:0] freq_adj;

   ibsc_div u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   ibsc_cordic u_cordic (
      .clock(clock),
      .reset(reset),
      .cordic_req(cordic_req),
      .cordic_rsp(cordic_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      d_new = req_sample - base_ff;
      a_new = d_new[15] ? 17'(-{d_new[15], d_new}) : {1'b0, d_new};
      bal_go = bal_en_ff && ((req_now_ms - last_ff) > {16'h0000, interval_ff});
      detect = a_ff > {7'b0000000, thr_ff};
      vdi_prod = 25'($signed({{16{cordic_rsp.phase[8]}}, cordic_rsp.phase}) * 25'sd100);

      cordic_req.start = launch_ff && (state_ff == ST_CORDIC);
      cordic_req.x = base_ff;
      cordic_req.y = d_ff;

      div_req.start = launch_ff && (state_ff != ST_CORDIC);
      div_req.num = '0;
      div_req.den = 16'd1;
      unique case (state_ff)
         ST_DIV_CAL: begin
            div_req.num = {sum_ff[23], sum_ff};
            div_req.den = 16'(CAL_SAMPLES);
         end
         ST_DIV_BAL: begin
            div_req.num = 25'($signed({{9{base_ff[15]}}, base_ff}) * 25'sd49)
                          + $signed({{9{s_ff[15]}}, s_ff});
            div_req.den = 16'd50;
         end
         ST_DIV_A10: begin
            div_req.num = $signed({8'h00, a_ff});
            div_req.den = 16'd10;
         end
         ST_DIV_VDI: begin
            div_req.num = vdi_prod;
            div_req.den = {4'h0, a10p1_ff};
         end
         default: begin
            div_req.num = '0;
            div_req.den = 16'd1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      last_in = last_ff;
      s_in = s_ff;
      now_in = now_ff;
      d_in = d_ff;
      a_in = a_ff;
      cal_in = cal_ff;
      tone_in = tone_ff;
      a10p1_in = a10p1_ff;
      vdi_in = vdi_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_cal_in = out_cal_ff;
      out_diff_in = out_diff_ff;
      out_vdi_in = out_vdi_ff;
      out_tone_in = out_tone_ff;
      out_freq_in = out_freq_ff;
      freq_sum = 18'd500 + {a_ff, 1'b0};
      freq_adj = 16'd0;
      if (vdi_ff < -8'sd30) begin
         freq_adj = 16'd200;
      end else if (vdi_ff > 8'sd30) begin
         freq_adj = 16'd400;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               s_in = req_sample;
               now_in = req_now_ms;
               tone_in = 1'b0;
               vdi_in = '0;
               if (count_ff < 9'(CAL_SAMPLES)) begin
                  cal_in = 1'b1;
                  sum_in = sum_ff + {{8{req_sample[15]}}, req_sample};
                  count_in = count_ff + 9'd1;
                  state_in = (count_ff + 9'd1 == 9'(CAL_SAMPLES)) ? ST_DIV_CAL : ST_DONE;
               end else begin
                  cal_in = 1'b0;
                  d_in = d_new;
                  a_in = a_new;
                  if (bal_go) begin
                     state_in = ST_DIV_BAL;
                  end else if (a_new > {7'b0000000, thr_ff}) begin
                     state_in = ST_CORDIC;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DIV_CAL: begin
            if (div_rsp.done) begin
               base_in = div_rsp.quo[15:0];
               state_in = ST_DONE;
            end
         end
         ST_DIV_BAL: begin
            if (div_rsp.done) begin
               base_in = div_rsp.quo[15:0];
               last_in = now_ff;
               state_in = detect ? ST_CORDIC : ST_DONE;
            end
         end
         ST_CORDIC: begin
            if (cordic_rsp.done) begin
               state_in = ST_DIV_A10;
            end
         end
         ST_DIV_A10: begin
            if (div_rsp.done) begin
               a10p1_in = div_rsp.quo[11:0] + 12'd1;
               state_in = ST_DIV_VDI;
            end
         end
         ST_DIV_VDI: begin
            if (div_rsp.done) begin
               tone_in = 1'b1;
               if (div_rsp.quo > 25'sd100) begin
                  vdi_in = 8'sd100;
               end else if (div_rsp.quo < -25'sd100) begin
                  vdi_in = -8'sd100;
               end else begin
                  vdi_in = div_rsp.quo[7:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_cal_in = cal_ff;
               out_diff_in = cal_ff ? 16'sd0 : d_ff;
               out_vdi_in = tone_ff ? vdi_ff : 8'sd0;
               out_tone_in = tone_ff;
               out_freq_in = tone_ff ? 16'(freq_sum) + freq_adj : 16'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      launch_in = (state_in != state_ff) && (state_in != ST_IDLE) && (state_in != ST_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         launch_ff <= 1'b0;
         thr_ff <= THRESHOLD_RESET;
         bal_en_ff <= 1'b1;
         interval_ff <= INTERVAL_RESET;
         base_ff <= '0;
         sum_ff <= '0;
         count_ff <= '0;
         last_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launch_ff <= launch_in;
         base_ff <= base_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         last_ff <= last_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_DETECT_THRESHOLD: thr_ff <= csr_data[9:0];
               REG_BALANCE_ENABLE: bal_en_ff <= csr_data[0];
               REG_BALANCE_INTERVAL: interval_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      s_ff <= s_in;
      now_ff <= now_in;
      d_ff <= d_in;
      a_ff <= a_in;
      cal_ff <= cal_in;
      tone_ff <= tone_in;
      a10p1_ff <= a10p1_in;
      vdi_ff <= vdi_in;
      out_cal_ff <= out_cal_in;
      out_diff_ff <= out_diff_in;
      out_vdi_ff <= out_vdi_in;
      out_tone_ff <= out_tone_in;
      out_freq_ff <= out_freq_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_calibrating = out_cal_ff;
   assign rsp_difference = out_diff_ff;
   assign rsp_target_index = out_vdi_ff;
   assign rsp_tone_on = out_tone_ff;
   assign rsp_tone_freq = out_freq_ff;

endmodule

>>> rtl/ibsc_div.sv
// shared iterative signed divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module ibsc_div (
   input  logic clock,
   input  logic reset,
   input  ibsc_pkg::div_req_type div_req,
   output ibsc_pkg::div_rsp_type div_rsp
);
   import ibsc_pkg::*;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic neg_ff, neg_in;
   logic [15:0] den_ff, den_in;
   logic [15:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [DIV_BITS:0] mag;
   logic [16:0] shifted;

   always_comb begin
      mag = div_req.num[DIV_BITS] ? -div_req.num : div_req.num;
      shifted = {rem_ff, quo_ff[DIV_BITS-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in = div_req.num[DIV_BITS];
         den_in = div_req.den;
         rem_in = '0;
         quo_in = mag[DIV_BITS-1:0];
         cnt_in = 5'(DIV_BITS);
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 16'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

>>> rtl/ibsc_cordic.sv
// iterative cordic vectoring unit giving the phase in units of 57.3 per radian
`timescale 1ns / 1ps
module ibsc_cordic (
   input  logic clock,
   input  logic reset,
   input  ibsc_pkg::cordic_req_type cordic_req,
   output ibsc_pkg::cordic_rsp_type cordic_rsp
);
   import ibsc_pkg::*;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic xneg_ff, xneg_in;
   logic yneg_ff, yneg_in;
   logic zero_ff, zero_in;
   logic signed [37:0] ax_ff, ax_in;
   logic signed [37:0] ay_ff, ay_in;
   logic signed [16:0] z_ff, z_in;
   logic [3:0] i_ff, i_in;
   logic signed [16:0] absx, absy;
   logic signed [37:0] sx, sy;
   logic signed [16:0] tab;
   logic signed [16:0] zc, mag;
   logic [7:0] mag_int;

   always_comb begin
      absx = cordic_req.x[15] ? -{cordic_req.x[15], cordic_req.x}
                              : {cordic_req.x[15], cordic_req.x};
      absy = cordic_req.y[15] ? -{cordic_req.y[15], cordic_req.y}
                              : {cordic_req.y[15], cordic_req.y};
      sx = ax_ff >>> i_ff;
      sy = ay_ff >>> i_ff;
      tab = $signed({3'b000, atan_unit(i_ff)});
      busy_in = busy_ff;
      done_in = 1'b0;
      xneg_in = xneg_ff;
      yneg_in = yneg_ff;
      zero_in = zero_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      z_in = z_ff;
      i_in = i_ff;
      if (cordic_req.start) begin
         busy_in = 1'b1;
         xneg_in = cordic_req.x[15];
         yneg_in = cordic_req.y[15];
         zero_in = (cordic_req.x == 16'sd0) && (cordic_req.y == 16'sd0);
         ax_in = $signed({5'b00000, absx, 16'h0000});
         ay_in = $signed({5'b00000, absy, 16'h0000});
         z_in = '0;
         i_in = '0;
      end else if (busy_ff) begin
         if (ay_ff > 38'sd0) begin
            ax_in = ax_ff + sy;
            ay_in = ay_ff - sx;
            z_in = z_ff + tab;
         end else begin
            ax_in = ax_ff - sy;
            ay_in = ay_ff + sx;
            z_in = z_ff - tab;
         end
         i_in = i_ff + 4'd1;
         if (i_ff == 4'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      zc = z_ff[16] ? 17'sd0 : z_ff;
      mag = xneg_ff ? PI_UNITS - zc : zc;
      mag_int = (mag[16] || zero_ff) ? 8'd0 : mag[15:8];
      cordic_rsp.done = done_ff;
      cordic_rsp.phase = yneg_ff ? -$signed({1'b0, mag_int}) : $signed({1'b0, mag_int});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      xneg_ff <= xneg_in;
      yneg_ff <= yneg_in;
      zero_ff <= zero_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      z_ff <= z_in;
      i_ff <= i_in;
   end

endmodule

>>> tb/ibsc_checker.sv
// checker: predicts classifier results from accepted transactions and compares them
`timescale 1ns / 1ps
module ibsc_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic signed [15:0] req_sample,
   input  logic [31:0] req_now_ms,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic rsp_calibrating,
   input  logic signed [15:0] rsp_difference,
   input  logic signed [7:0] rsp_target_index,
   input  logic rsp_tone_on,
   input  logic [15:0] rsp_tone_freq,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   output int fail_count,
   output int pending
);
   import ibsc_pkg::*;

   typedef struct packed {
      logic calibrating;
      logic signed [15:0] difference;
      logic signed [7:0] target_index;
      logic tone_on;
      logic [15:0] tone_freq;
   } classification_type;

   classification_type expected_results[$];

   logic [9:0] threshold;
   logic balance_on;
   logic [15:0] interval;
   int baseline;
   int cal_sum;
   int cal_count;
   logic [31:0] last_balance;

   localparam int ATAN_TAB[15] = '{11521, 6801, 3594, 1824, 916, 458, 229, 115, 57, 29,
                                   14, 7, 4, 2, 1};

   function automatic int phase_573(input int x, input int y);
      longint ax, ay, nx, ny;
      int z, mag;
      z = 0;
      if (x == 0 && y == 0) return 0;
      ax = longint'(x < 0 ? -x : x) * 65536;
      ay = longint'(y < 0 ? -y : y) * 65536;
      for (int i = 0; i < 15; i++) begin
         if (ay > 0) begin
            nx = ax + (ay >>> i);
            ny = ay - (ax >>> i);
            z += ATAN_TAB[i];
         end else begin
            nx = ax - (ay >>> i);
            ny = ay + (ax >>> i);
            z -= ATAN_TAB[i];
         end
         ax = nx;
         ay = ny;
      end
      if (z < 0) z = 0;
      mag = (x < 0) ? (46083 - z) : z;
      if (mag < 0) mag = 0;
      mag = mag >>> 8;
      return (y < 0) ? -mag : mag;
   endfunction

   task automatic classify(input logic signed [15:0] smp, input logic [31:0] now);
      classification_type r;
      logic [15:0] dw;
      int s, d, a, vdi, freq, ph;
      logic [31:0] elapsed;
      r = '0;
      s = smp;
      if (cal_count < CAL_SAMPLES) begin
         cal_sum += s;
         cal_count++;
         if (cal_count >= CAL_SAMPLES) baseline = cal_sum / int'(CAL_SAMPLES);
         r.calibrating = 1'b1;
      end else begin
         dw = smp - 16'(baseline);
         d = signed'(dw);
         a = d < 0 ? -d : d;
         elapsed = now - last_balance;
         if (balance_on && elapsed > {16'd0, interval}) begin
            baseline = (49 * baseline + s) / 50;
            last_balance = now;
         end
         vdi = 0;
         freq = 0;
         if (a > int'(threshold)) begin
            ph = phase_573(baseline, d);
            vdi = (ph * 100) / (a / 10 + 1);
            if (vdi < -100) vdi = -100;
            if (vdi > 100) vdi = 100;
            freq = 500 + 2 * a;
            if (vdi < -30) freq += 200;
            else if (vdi > 30) freq += 400;
            r.tone_on = 1'b1;
         end
         r.difference = dw;
         r.target_index = vdi[7:0];
         r.tone_freq = freq[15:0];
      end
      expected_results.push_back(r);
   endtask

   task automatic compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   assign pending = expected_results.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      classification_type e;
      if (reset) begin
         threshold <= THRESHOLD_RESET;
         balance_on <= 1'b1;
         interval <= INTERVAL_RESET;
         baseline = 0;
         cal_sum = 0;
         cal_count = 0;
         last_balance = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DETECT_THRESHOLD: threshold <= csr_data[9:0];
               REG_BALANCE_ENABLE: balance_on <= csr_data[0];
               REG_BALANCE_INTERVAL: interval <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t unexpected transaction: expected none actual freq %0d",
                        $time, rsp_tone_freq);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               compare_field("calibrating", e.calibrating, rsp_calibrating);
               compare_field("difference", e.difference, rsp_difference);
               compare_field("target_index", e.target_index, rsp_target_index);
               compare_field("tone_on", e.tone_on, rsp_tone_on);
               compare_field("tone_freq", e.tone_freq, rsp_tone_freq);
            end
         end
         if (req_valid && req_ready) classify(req_sample, req_now_ms);
      end
   end
endmodule

>>> tb/tb.sv
// testbench top: clock, reset, stimulus and verdict for the signal classifier
`timescale 1ns / 1ps
module tb;
   import ibsc_pkg::*;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic signed [15:0] req_sample;
   logic [31:0] req_now_ms;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_calibrating;
   logic signed [15:0] rsp_difference;
   logic signed [7:0] rsp_target_index;
   logic rsp_tone_on;
   logic [15:0] rsp_tone_freq;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_data;
   int fail_count, pending;
   bit no_idle;
   logic [31:0] clock_ms;
   int cal_total, base_est;

   always #5 clock = ~clock;

   induction_balance_signal_classifier u_top (.*);

   ibsc_checker u_checker (.*);

   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_sample(input logic [15:0] smp, input logic [31:0] now);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic step_time();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) clock_ms += $urandom_range(1, 50);
      else if (r < 90) clock_ms += $urandom_range(300, 800);
      else clock_ms = $urandom;
   endtask

   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 16'(base_est + $signed($urandom_range(0, 200)) - 100);
      if (r < 75) return 16'(base_est + $signed($urandom_range(0, 4000)) - 2000);
      return 16'($urandom);
   endfunction

   always @(posedge clock) begin
      if (no_idle || $urandom_range(0, 99) < 70) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(10, 60)) @(posedge clock);
      end else rsp_ready <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("** induction_balance_signal_classifier: FAILED **");
      $finish;
   end

   initial begin
      logic [15:0] s;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      req_now_ms <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      no_idle = 1'b0;
      clock_ms = 0;
      cal_total = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_DETECT_THRESHOLD, 16'd0);
      write_reg(REG_BALANCE_ENABLE, 16'd0);
      write_reg(REG_BALANCE_INTERVAL, 16'd1);
      write_reg(2'd3, 16'hFFFF);

      // calibration, extremes first
      for (int i = 0; i < CAL_SAMPLES; i++) begin
         if (i == 0) s = 16'h8000;
         else if (i == 1) s = 16'h7FFF;
         else s = 16'(1000 + $signed($urandom_range(0, 600)) - 300);
         cal_total += signed'(s);
         clock_ms += 10;
         send_sample(s, clock_ms);
      end
      base_est = cal_total / int'(CAL_SAMPLES);

      // directed: fixed baseline, full-scale difference, zero difference
      send_sample(16'(base_est - 32768), clock_ms);
      send_sample(16'(base_est), clock_ms);
      send_sample(16'(base_est + 1), clock_ms);
      send_sample(16'(base_est - 1), clock_ms);
      send_sample(16'(base_est + 32767), clock_ms);
      send_sample(16'h8000, clock_ms);
      send_sample(16'h7FFF, clock_ms);
      send_sample(16'h0000, clock_ms);
      drain();
      write_reg(REG_DETECT_THRESHOLD, 16'd1000);
      send_sample(16'(base_est + 1000), clock_ms);
      send_sample(16'(base_est + 1001), clock_ms);
      send_sample(16'(base_est - 1001), clock_ms);
      send_sample(16'h8000, clock_ms);
      drain();
      write_reg(REG_BALANCE_ENABLE, 16'd1);
      write_reg(REG_DETECT_THRESHOLD, 16'hFC32);
      send_sample(16'(base_est + 3000), 32'd1);
      send_sample(16'(base_est + 3000), 32'd2);
      send_sample(16'(base_est - 5000), 32'd4);
      send_sample(16'(base_est - 5000), 32'hFFFF_FFFF);
      send_sample(16'(base_est + 20000), 32'd5);
      drain();
      write_reg(REG_BALANCE_INTERVAL, 16'hFFFF);
      send_sample(16'(base_est + 9000), 32'd65540);
      send_sample(16'(base_est + 9000), 32'h8000_0000);
      send_sample(16'(base_est - 9000), 32'h8000_FFFF);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         no_idle = (ph == 2);
         case (ph)
            0: begin
               write_reg(REG_DETECT_THRESHOLD, 16'd50);
               write_reg(REG_BALANCE_INTERVAL, 16'd500);
            end
            1: begin
               write_reg(REG_DETECT_THRESHOLD, 16'd0);
               write_reg(REG_BALANCE_INTERVAL, 16'd1);
            end
            2: begin
               write_reg(REG_DETECT_THRESHOLD, 16'd1000);
               write_reg(REG_BALANCE_INTERVAL, 16'hFFFF);
            end
            default: begin
               write_reg(REG_DETECT_THRESHOLD, 16'($urandom));
               write_reg(REG_BALANCE_INTERVAL, 16'($urandom_range(1, 2000)));
            end
         endcase
         write_reg(REG_BALANCE_ENABLE, 16'($urandom));
         for (int i = 0; i < 87; i++) begin
            step_time();
            send_sample(pick_sample(), clock_ms);
         end
         drain();
      end
      no_idle = 1'b0;

      if (fail_count == 0) begin
         $display("** induction_balance_signal_classifier: PASSED **");
      end else begin
         $display("** induction_balance_signal_classifier: FAILED **");
      end
      $finish;
   end
endmodule
